FILE: rtl/skid_steer_odometry_integrator_core_assert.svh
// Assertion macros shared by the odometry integrator RTL
`ifndef SKID_STEER_ODOMETRY_INTEGRATOR_CORE_ASSERT_SVH
`define SKID_STEER_ODOMETRY_INTEGRATOR_CORE_ASSERT_SVH

// same-cycle implication
`define SSOI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SSOI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ssoi_pkg.sv
// Types, constants and tables of the odometry integrator
`timescale 1ns / 1ps
package ssoi_pkg;

   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] REG_DIST_PER_PULSE = 2'd0;
   localparam logic [1:0] REG_INV_WHEEL_BASE = 2'd1;
   localparam logic [1:0] REG_TICK_RATE      = 2'd2;

   localparam logic [31:0] RST_DIST_PER_PULSE = 32'd3748065;
   localparam logic [31:0] RST_INV_WHEEL_BASE = 32'd55924053;
   localparam logic [15:0] RST_TICK_RATE      = 16'd100;

   localparam logic signed [31:0] PI_Q28          = 32'sd843314857;
   localparam logic signed [31:0] TWO_PI_Q28      = 32'sd1686629713;
   localparam logic signed [31:0] HALF_PI_Q28     = 32'sd421657428;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam int ATAN_LEN = 30;
   localparam int ATAN_IDX_W = 5;

   typedef enum logic [2:0] {
      SHR_0,
      SHR_16,
      SHR_18,
      SHR_21,
      SHR_25,
      SHR_32
   } shift_type;

   typedef struct packed {
      logic [31:0] dist_per_pulse;
      logic [31:0] inv_wheel_base;
      logic [15:0] tick_rate;
   } csr_cfg_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [31:0] b;
      shift_type   sh;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] res;
   } mul_rsp_type;

   typedef struct packed {
      logic               start;
      logic signed [31:0] angle;
   } cordic_req_type;

   typedef struct packed {
      logic        busy;
      logic [31:0] cos_mag;
      logic        cos_neg;
      logic [31:0] sin_mag;
      logic        sin_neg;
   } cordic_rsp_type;

   function automatic logic [27:0] atan_q28(input logic [ATAN_IDX_W-1:0] idx);
      logic [27:0] v;
      case (idx)
         5'd0:  v = 28'd210828714;
         5'd1:  v = 28'd124459457;
         5'd2:  v = 28'd65760959;
         5'd3:  v = 28'd33381290;
         5'd4:  v = 28'd16755422;
         5'd5:  v = 28'd8385879;
         5'd6:  v = 28'd4193963;
         5'd7:  v = 28'd2097109;
         5'd8:  v = 28'd1048571;
         5'd9:  v = 28'd524287;
         5'd10: v = 28'd262144;
         5'd11: v = 28'd131072;
         5'd12: v = 28'd65536;
         5'd13: v = 28'd32768;
         5'd14: v = 28'd16384;
         5'd15: v = 28'd8192;
         5'd16: v = 28'd4096;
         5'd17: v = 28'd2048;
         5'd18: v = 28'd1024;
         5'd19: v = 28'd512;
         5'd20: v = 28'd256;
         5'd21: v = 28'd128;
         5'd22: v = 28'd64;
         5'd23: v = 28'd32;
         5'd24: v = 28'd16;
         5'd25: v = 28'd8;
         5'd26: v = 28'd4;
         5'd27: v = 28'd2;
         5'd28: v = 28'd1;
         default: v = 28'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/ssoi_if.sv
// Item channel interfaces: encoder counts in, pose and velocities out
`timescale 1ns / 1ps
interface ssoi_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] front_left_count;
   logic signed [15:0] front_right_count;
   logic signed [15:0] rear_left_count;
   logic signed [15:0] rear_right_count;

   modport source (
      output valid, front_left_count, front_right_count, rear_left_count, rear_right_count,
      input  ready
   );
   modport sink (
      input  valid, front_left_count, front_right_count, rear_left_count, rear_right_count,
      output ready
   );
endinterface

interface ssoi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pose_x;
   logic signed [31:0] pose_y;
   logic signed [30:0] heading;
   logic signed [31:0] forward_speed;
   logic signed [31:0] yaw_rate;

   modport source (
      output valid, pose_x, pose_y, heading, forward_speed, yaw_rate,
      input  ready
   );
   modport sink (
      input  valid, pose_x, pose_y, heading, forward_speed, yaw_rate,
      output ready
   );
endinterface

FILE: rtl/ssoi_csr.sv
// APB configuration registers of the odometry integrator
`timescale 1ns / 1ps
module ssoi_csr import ssoi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output csr_cfg_type           cfg
);

   logic [31:0] dist_per_pulse_ff;
   logic [31:0] inv_wheel_base_ff;
   logic [15:0] tick_rate_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_per_pulse_ff <= RST_DIST_PER_PULSE;
         inv_wheel_base_ff <= RST_INV_WHEEL_BASE;
         tick_rate_ff      <= RST_TICK_RATE;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_DIST_PER_PULSE: dist_per_pulse_ff <= pwdata;
            REG_INV_WHEEL_BASE: inv_wheel_base_ff <= pwdata;
            REG_TICK_RATE:      tick_rate_ff      <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_DIST_PER_PULSE: prdata = dist_per_pulse_ff;
         REG_INV_WHEEL_BASE: prdata = inv_wheel_base_ff;
         REG_TICK_RATE:      prdata = {16'd0, tick_rate_ff};
         default:            prdata = 32'd0;
      endcase
   end

   assign cfg.dist_per_pulse = dist_per_pulse_ff;
   assign cfg.inv_wheel_base = inv_wheel_base_ff;
   assign cfg.tick_rate      = tick_rate_ff;

endmodule

FILE: rtl/ssoi_mul.sv
// Shared 64x32 multiplier: two 32x32 partial products, sum and a per-request right shift
`timescale 1ns / 1ps
module ssoi_mul import ssoi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LO,
      PH_HI,
      PH_SUM
   } phase_type;

   phase_type   phase_ff;
   logic [63:0] a_ff;
   logic [31:0] b_ff;
   shift_type   sh_ff;
   logic [63:0] lo_ff;
   logic [63:0] prod_ff;
   logic [95:0] sum;
   logic [95:0] shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (req.start) begin
                  a_ff     <= req.a;
                  b_ff     <= req.b;
                  sh_ff    <= req.sh;
                  phase_ff <= PH_LO;
               end
            end
            PH_LO: begin
               prod_ff  <= a_ff[31:0] * b_ff;
               phase_ff <= PH_HI;
            end
            PH_HI: begin
               lo_ff    <= prod_ff;
               prod_ff  <= a_ff[63:32] * b_ff;
               phase_ff <= PH_SUM;
            end
            PH_SUM: begin
               phase_ff <= PH_IDLE;
            end
            default: phase_ff <= PH_IDLE;
         endcase
      end
   end

   assign sum = {32'd0, lo_ff} + {prod_ff, 32'd0};

   always_comb begin
      case (sh_ff)
         SHR_0:   shifted = sum;
         SHR_16:  shifted = sum >> 16;
         SHR_18:  shifted = sum >> 18;
         SHR_21:  shifted = sum >> 21;
         SHR_25:  shifted = sum >> 25;
         SHR_32:  shifted = sum >> 32;
         default: shifted = sum;
      endcase
   end

   assign rsp.done = (phase_ff == PH_SUM);
   assign rsp.res  = shifted[63:0];

endmodule

FILE: rtl/ssoi_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle
`timescale 1ns / 1ps
module ssoi_cordic import ssoi_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic           clock,
   input  logic           reset,
   input  cordic_req_type req,
   output cordic_rsp_type rsp
);

   localparam logic [ATAN_IDX_W-1:0] LAST = ATAN_IDX_W'(CORDIC_STEPS - 1);

   logic                  busy_ff;
   logic                  flip_ff;
   logic signed [33:0]    x_ff;
   logic signed [33:0]    y_ff;
   logic signed [31:0]    z_ff;
   logic [ATAN_IDX_W-1:0] i_ff;

   logic signed [31:0] z_fold;
   logic               flip_fold;
   logic signed [33:0] x_sh;
   logic signed [33:0] y_sh;
   logic signed [31:0] at;
   logic [33:0]        x_abs;
   logic [33:0]        y_abs;

   always_comb begin
      z_fold    = req.angle;
      flip_fold = 1'b0;
      if (req.angle > HALF_PI_Q28) begin
         z_fold    = req.angle - PI_Q28;
         flip_fold = 1'b1;
      end else if (req.angle < -HALF_PI_Q28) begin
         z_fold    = req.angle + PI_Q28;
         flip_fold = 1'b1;
      end
   end

   assign x_sh = x_ff >>> i_ff;
   assign y_sh = y_ff >>> i_ff;
   assign at   = $signed({4'd0, atan_q28(i_ff)});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         flip_ff <= flip_fold;
         x_ff    <= CORDIC_GAIN_Q30;
         y_ff    <= 34'sd0;
         z_ff    <= z_fold;
         i_ff    <= '0;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_ff <= x_ff - y_sh;
            y_ff <= y_ff + x_sh;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + y_sh;
            y_ff <= y_ff - x_sh;
            z_ff <= z_ff + at;
         end
         i_ff <= i_ff + 1'b1;
         if (i_ff == LAST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign x_abs = x_ff[33] ? 34'(-x_ff) : 34'(x_ff);
   assign y_abs = y_ff[33] ? 34'(-y_ff) : 34'(y_ff);

   assign rsp.busy    = busy_ff;
   assign rsp.cos_mag = (x_abs[33:32] != 2'd0) ? 32'hFFFF_FFFF : x_abs[31:0];
   assign rsp.sin_mag = (y_abs[33:32] != 2'd0) ? 32'hFFFF_FFFF : y_abs[31:0];
   assign rsp.cos_neg = flip_ff ? (x_ff > 0) : x_ff[33];
   assign rsp.sin_neg = flip_ff ? (y_ff > 0) : y_ff[33];

endmodule

FILE: rtl/skid_steer_odometry_integrator_core.sv
// Skid-steer odometry integrator: sequencer, state and result register
//
// req_ch carries one item per control tick: four signed 16-bit wheel pulse counts.
// rsp_ch returns one item per accepted input: pose_x, pose_y (Q16.16, saturating),
// heading (Q3.28, within +-pi), forward_speed and yaw_rate (Q16.16, saturating).
// csr_* is an APB write/read port for dist_per_pulse (0x0), inv_wheel_base (0x4)
// and tick_rate (0x8); pready is always high.
// An item makes eight passes through the shared 64x32 multiplier, with the CORDIC
// running one micro-rotation per cycle alongside four of them; the last two passes
// wait for the CORDIC to finish.
// req_ch.ready is high only while the sequencer is idle, so the block works on one
// item at a time. The result register frees the sequencer: a new item is accepted
// while the previous result waits; if rsp_ch stalls, the next result is held in the
// sequencer until the register drains.
// Synchronous reset clears pose and heading to zero and loads the register defaults.
`timescale 1ns / 1ps
`include "skid_steer_odometry_integrator_core_assert.svh"
module skid_steer_odometry_integrator_core import ssoi_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   ssoi_req_if.sink              req_ch,
   ssoi_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_R,
      ST_MUL_DTH,
      ST_WRAP,
      ST_MUL_Q,
      ST_MUL_SPD,
      ST_MUL_YAWA,
      ST_MUL_YAW,
      ST_WAIT_TRIG,
      ST_MUL_DX,
      ST_MUL_DY,
      ST_UPD_Y,
      ST_FINISH
   } state_type;

   csr_cfg_type    cfg;
   mul_req_type    mul_req;
   mul_rsp_type    mul_rsp;
   cordic_req_type cordic_req;
   cordic_rsp_type cordic_rsp;

   state_type          state_ff, state_in;
   logic               go_ff, go_in;
   logic               cgo_ff, cgo_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] head_ff, head_in;
   logic signed [31:0] pos_x_ff, pos_x_in;
   logic signed [31:0] pos_y_ff, pos_y_in;
   logic [17:0]        sm_ff, sm_in;
   logic               s_neg_ff, s_neg_in;
   logic [17:0]        dm_ff, dm_in;
   logic               d_neg_ff, d_neg_in;
   logic [49:0]        r_ff, r_in;
   logic [49:0]        q_ff, q_in;
   logic [49:0]        ya_ff, ya_in;
   logic [52:0]        dth_ff, dth_in;
   logic [33:0]        mv_ff, mv_in;
   logic [31:0]        speed_ff, speed_in;
   logic [31:0]        yaw_ff, yaw_in;
   logic [31:0]        out_x_ff, out_x_in;
   logic [31:0]        out_y_ff, out_y_in;
   logic [30:0]        out_head_ff, out_head_in;
   logic [31:0]        out_speed_ff, out_speed_in;
   logic [31:0]        out_yaw_ff, out_yaw_in;

   logic signed [16:0] sl;
   logic signed [16:0] sr;
   logic signed [17:0] s_sum;
   logic signed [17:0] d_dif;
   logic [30:0]        dth_cap;
   logic signed [32:0] dth_s;
   logic signed [33:0] h_sum;
   logic signed [33:0] h_wrap;

   logic               mul_step;
   logic               pos_step;
   logic               req_fire;
   logic               mul_r_go;
   logic               head_ok;

   function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] mag);
      logic [31:0] v;
      if (neg) begin
         v = (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
      end else begin
         v = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end
      return v;
   endfunction

   function automatic logic signed [31:0] advance(input logic signed [31:0] pos,
                                                  input logic neg,
                                                  input logic [33:0] mv);
      logic signed [35:0] step;
      logic signed [35:0] sum;
      logic signed [31:0] v;
      step = neg ? -$signed({2'b00, mv}) : $signed({2'b00, mv});
      sum  = 36'(pos) + step;
      if (sum > 36'sh0_7FFF_FFFF) begin
         v = 32'sh7FFF_FFFF;
      end else if (sum < -36'sh0_8000_0000) begin
         v = 32'sh8000_0000;
      end else begin
         v = sum[31:0];
      end
      return v;
   endfunction

   ssoi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   ssoi_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   ssoi_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cordic_req),
      .rsp   (cordic_rsp)
   );

   assign cordic_req.start = cgo_ff;
   assign cordic_req.angle = head_ff;

   // operand select for the shared multiplier
   always_comb begin
      mul_req.start = go_ff;
      mul_req.a     = 64'd0;
      mul_req.b     = 32'd0;
      mul_req.sh    = SHR_0;
      case (state_ff)
         ST_MUL_R: begin
            mul_req.a = {46'd0, dm_ff};
            mul_req.b = cfg.dist_per_pulse;
         end
         ST_MUL_DTH: begin
            mul_req.a  = {22'd0, r_ff[49:8]};
            mul_req.b  = cfg.inv_wheel_base;
            mul_req.sh = SHR_21;
         end
         ST_MUL_Q: begin
            mul_req.a = {46'd0, sm_ff};
            mul_req.b = cfg.dist_per_pulse;
         end
         ST_MUL_SPD: begin
            mul_req.a  = {14'd0, q_ff};
            mul_req.b  = {16'd0, cfg.tick_rate};
            mul_req.sh = SHR_18;
         end
         ST_MUL_YAWA: begin
            mul_req.a  = {14'd0, r_ff};
            mul_req.b  = {16'd0, cfg.tick_rate};
            mul_req.sh = SHR_16;
         end
         ST_MUL_YAW: begin
            mul_req.a  = {14'd0, ya_ff};
            mul_req.b  = cfg.inv_wheel_base;
            mul_req.sh = SHR_25;
         end
         ST_MUL_DX: begin
            mul_req.a  = {30'd0, q_ff[49:16]};
            mul_req.b  = cordic_rsp.cos_mag;
            mul_req.sh = SHR_32;
         end
         ST_MUL_DY: begin
            mul_req.a  = {30'd0, q_ff[49:16]};
            mul_req.b  = cordic_rsp.sin_mag;
            mul_req.sh = SHR_32;
         end
         default: ;
      endcase
   end

   assign sl    = 17'(req_ch.front_left_count) + 17'(req_ch.rear_left_count);
   assign sr    = 17'(req_ch.front_right_count) + 17'(req_ch.rear_right_count);
   assign s_sum = 18'(sl) + 18'(sr);
   assign d_dif = 18'(sr) - 18'(sl);

   // heading step: clamp to +-2pi, add, wrap once
   always_comb begin
      dth_cap = (dth_ff > 53'(TWO_PI_Q28)) ? 31'(TWO_PI_Q28) : dth_ff[30:0];
      dth_s   = d_neg_ff ? -$signed({2'b00, dth_cap}) : $signed({2'b00, dth_cap});
      h_sum   = 34'(head_ff) + 34'(dth_s);
      h_wrap  = h_sum;
      if (h_sum > 34'(PI_Q28)) begin
         h_wrap = h_sum - 34'(TWO_PI_Q28);
      end else if (h_sum < -34'(PI_Q28)) begin
         h_wrap = h_sum + 34'(TWO_PI_Q28);
      end
   end

   always_comb begin
      state_in     = state_ff;
      go_in        = 1'b0;
      cgo_in       = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      head_in      = head_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      sm_in        = sm_ff;
      s_neg_in     = s_neg_ff;
      dm_in        = dm_ff;
      d_neg_in     = d_neg_ff;
      r_in         = r_ff;
      q_in         = q_ff;
      ya_in        = ya_ff;
      dth_in       = dth_ff;
      mv_in        = mv_ff;
      speed_in     = speed_ff;
      yaw_in       = yaw_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_head_in  = out_head_ff;
      out_speed_in = out_speed_ff;
      out_yaw_in   = out_yaw_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               s_neg_in = s_sum[17];
               sm_in    = s_sum[17] ? 18'(-s_sum) : 18'(s_sum);
               d_neg_in = d_dif[17];
               dm_in    = d_dif[17] ? 18'(-d_dif) : 18'(d_dif);
               go_in    = 1'b1;
               state_in = ST_MUL_R;
            end
         end
         ST_MUL_R: begin
            if (mul_rsp.done) begin
               r_in     = mul_rsp.res[49:0];
               go_in    = 1'b1;
               state_in = ST_MUL_DTH;
            end
         end
         ST_MUL_DTH: begin
            if (mul_rsp.done) begin
               dth_in   = mul_rsp.res[52:0];
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            head_in  = h_wrap[31:0];
            cgo_in   = 1'b1;
            go_in    = 1'b1;
            state_in = ST_MUL_Q;
         end
         ST_MUL_Q: begin
            if (mul_rsp.done) begin
               q_in     = mul_rsp.res[49:0];
               go_in    = 1'b1;
               state_in = ST_MUL_SPD;
            end
         end
         ST_MUL_SPD: begin
            if (mul_rsp.done) begin
               speed_in = sat_mag(s_neg_ff, mul_rsp.res);
               go_in    = 1'b1;
               state_in = ST_MUL_YAWA;
            end
         end
         ST_MUL_YAWA: begin
            if (mul_rsp.done) begin
               ya_in    = mul_rsp.res[49:0];
               go_in    = 1'b1;
               state_in = ST_MUL_YAW;
            end
         end
         ST_MUL_YAW: begin
            if (mul_rsp.done) begin
               yaw_in   = sat_mag(d_neg_ff, mul_rsp.res);
               state_in = ST_WAIT_TRIG;
            end
         end
         ST_WAIT_TRIG: begin
            if (!cordic_rsp.busy && !cgo_ff) begin
               go_in    = 1'b1;
               state_in = ST_MUL_DX;
            end
         end
         ST_MUL_DX: begin
            if (mul_rsp.done) begin
               mv_in    = mul_rsp.res[33:0];
               go_in    = 1'b1;
               state_in = ST_MUL_DY;
            end
         end
         ST_MUL_DY: begin
            // x step lands in the first cycle, while the y product runs
            if (go_ff) begin
               pos_x_in = advance(pos_x_ff, s_neg_ff ^ cordic_rsp.cos_neg, mv_ff);
            end
            if (mul_rsp.done) begin
               mv_in    = mul_rsp.res[33:0];
               state_in = ST_UPD_Y;
            end
         end
         ST_UPD_Y: begin
            pos_y_in = advance(pos_y_ff, s_neg_ff ^ cordic_rsp.sin_neg, mv_ff);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_x_in     = pos_x_ff;
               out_y_in     = pos_y_ff;
               out_head_in  = head_ff[30:0];
               out_speed_in = speed_ff;
               out_yaw_in   = yaw_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         cgo_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff      <= 32'sd0;
         pos_x_ff     <= 32'sd0;
         pos_y_ff     <= 32'sd0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         cgo_ff       <= cgo_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         sm_ff        <= sm_in;
         s_neg_ff     <= s_neg_in;
         dm_ff        <= dm_in;
         d_neg_ff     <= d_neg_in;
         r_ff         <= r_in;
         q_ff         <= q_in;
         ya_ff        <= ya_in;
         dth_ff       <= dth_in;
         mv_ff        <= mv_in;
         speed_ff     <= speed_in;
         yaw_ff       <= yaw_in;
         out_x_ff     <= out_x_in;
         out_y_ff     <= out_y_in;
         out_head_ff  <= out_head_in;
         out_speed_ff <= out_speed_in;
         out_yaw_ff   <= out_yaw_in;
      end
   end

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.pose_x        = out_x_ff;
   assign rsp_ch.pose_y        = out_y_ff;
   assign rsp_ch.heading       = out_head_ff;
   assign rsp_ch.forward_speed = out_speed_ff;
   assign rsp_ch.yaw_rate      = out_yaw_ff;

   assign mul_step = state_ff inside {ST_MUL_R, ST_MUL_DTH, ST_MUL_Q, ST_MUL_SPD, ST_MUL_YAWA,
                                      ST_MUL_YAW, ST_MUL_DX, ST_MUL_DY};
   assign pos_step = state_ff inside {ST_MUL_DX, ST_MUL_DY, ST_UPD_Y};
   assign req_fire = req_ch.valid && req_ch.ready;
   assign mul_r_go = mul_req.start && (state_ff == ST_MUL_R);
   assign head_ok  = (head_ff <= PI_Q28) && (head_ff >= -PI_Q28);

   `SSOI_ASSERT_NOW(a_mul_done_in_step, clock, reset, mul_rsp.done, mul_step, "mul done off step")
   `SSOI_ASSERT_NOW(a_head_range, clock, reset, 1'b1, head_ok, "heading outside +-pi")
   `SSOI_ASSERT_NOW(a_trig_settled, clock, reset, pos_step, !cordic_rsp.busy, "trig not settled")
   `SSOI_ASSERT_NEXT(a_accept_starts_mul, clock, reset, req_fire, mul_r_go, "accept without multiply")

endmodule
